FILE: hw/rtl/throttle_brake_mode_input_scanner_defines.svh
// assertion helpers shared by the scanner modules
`ifndef THROTTLE_BRAKE_MODE_INPUT_SCANNER_DEFINES_SVH
`define THROTTLE_BRAKE_MODE_INPUT_SCANNER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TBMIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TBMIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tbmis_pkg.sv
package tbmis_pkg;

  // default parameter values
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int TIME_BITS_DEF   = 32;

  // fixed field widths
  localparam int CFG_SW    = 12;   // adc level registers
  localparam int CFG_TW    = 16;   // millisecond registers
  localparam int CFG_IDX_W = 3;
  localparam int PCT_W     = 7;
  localparam int MODE_W    = 2;
  localparam int LED_W     = 6;
  localparam int CMP_W     = 17;   // holds any sample and the summed start level
  localparam int NUM_W     = 19;   // 4095 * 100 fits
  localparam int DEN_W     = CFG_SW;

  localparam logic [PCT_W-1:0] PCT_SCALE      = 7'd100;
  localparam logic [PCT_W-1:0] BRAKE_OVERRIDE = 7'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THR_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_DB    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRK_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BRK_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_INT  = 3'd7;

  // register reset values
  localparam logic [CFG_SW-1:0] THR_MIN_RST   = 12'd400;
  localparam logic [CFG_SW-1:0] THR_DB_RST    = 12'd50;
  localparam logic [CFG_SW-1:0] THR_MAX_RST   = 12'd3400;
  localparam logic [CFG_SW-1:0] BRK_MIN_RST   = 12'd400;
  localparam logic [CFG_SW-1:0] BRK_MAX_RST   = 12'd3400;
  localparam logic [CFG_TW-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [CFG_TW-1:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [CFG_TW-1:0] SEND_INT_RST  = 16'd50;

  // riding modes
  localparam logic [MODE_W-1:0] MODE_ECO   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DRIVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SPORT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP_T,
    S_DIV_T,
    S_WAIT_T,
    S_PREP_B,
    S_DIV_B,
    S_WAIT_B,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;     // latch the request
    logic prep;       // register divider operands
    logic sel_brk;    // operands from the brake sample
    logic div_start;
    logic store_thr;  // keep throttle quotient
    logic finish;     // update state and load the output register
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  // x * 100 as shifts and adds
  function automatic logic [NUM_W-1:0] mul_scale(input logic [DEN_W-1:0] x);
    logic [NUM_W-1:0] xe;
    xe = NUM_W'(x);
    return (xe << 6) + (xe << 5) + (xe << 2);
  endfunction

endpackage

FILE: hw/rtl/tbmis_div.sv
`include "throttle_brake_mode_input_scanner_defines.svh"

module tbmis_div #(
  parameter int NUM_W = tbmis_pkg::NUM_W,
  parameter int DEN_W = tbmis_pkg::DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W:0]   rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;
  logic             ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_r};
    ge      = !trial[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? trial[DEN_W:0] : shifted;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

  `TBMIS_ASSERT_NOW(a_done_not_busy, done_r, !busy_r, "divider done while busy")
  `TBMIS_ASSERT_NEXT(a_start_busy, start, busy_r && !done_r, "divider start not taken")

endmodule

FILE: hw/rtl/tbmis_dp.sv
`include "throttle_brake_mode_input_scanner_defines.svh"

module tbmis_dp #(
  parameter int SAMPLE_BITS = tbmis_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = tbmis_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tbmis_pkg::cmd_t                    cmd,
  output tbmis_pkg::sts_t                    sts,
  input  logic                               cfg_we,
  input  logic [tbmis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbmis_pkg::CFG_TW-1:0]       cfg_data,
  input  logic [TIME_BITS-1:0]               in_now_ms,
  input  logic [SAMPLE_BITS-1:0]             in_throttle_sample,
  input  logic [SAMPLE_BITS-1:0]             in_brake_sample,
  input  logic                               in_button_pressed,
  input  logic                               in_link_connected,
  input  logic                               in_error_active,
  output logic [tbmis_pkg::PCT_W-1:0]        out_throttle_percent,
  output logic [tbmis_pkg::PCT_W-1:0]        out_brake_percent,
  output logic [tbmis_pkg::MODE_W-1:0]       out_mode_now,
  output logic                               out_mode_changed,
  output logic                               out_send_control,
  output logic [tbmis_pkg::LED_W-1:0]        out_led_pattern
);

  localparam int SW = tbmis_pkg::CFG_SW;
  localparam int TW = tbmis_pkg::CFG_TW;
  localparam int CW = tbmis_pkg::CMP_W;
  localparam int PW = tbmis_pkg::PCT_W;
  localparam int MW = tbmis_pkg::MODE_W;

  // configuration
  logic [SW-1:0] thr_min_r, thr_db_r, thr_max_r, brk_min_r, brk_max_r;
  logic [TW-1:0] debounce_r, long_press_r, send_int_r;

  // latched request
  logic [TIME_BITS-1:0]   now_r;
  logic [SAMPLE_BITS-1:0] thr_r, brk_r;
  logic                   btn_r, link_r, err_r;

  // block state
  logic                 btn_before_r;
  logic [TIME_BITS-1:0] press_start_r;
  logic [TIME_BITS-1:0] last_send_r;
  logic [MW-1:0]        mode_r;

  // divider operands and results
  logic [SW-1:0] diff_r, den_r;
  logic          zero_r, thr_zero_r;
  logic [PW-1:0] thr_quo_r;

  logic [tbmis_pkg::NUM_W-1:0] div_quo;
  logic                        div_busy;
  logic                        div_done;

  // output register
  logic [PW-1:0]                 o_thr_r, o_brk_r;
  logic                          o_chg_r, o_send_r;
  logic [tbmis_pkg::LED_W-1:0]   o_led_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_min_r    <= tbmis_pkg::THR_MIN_RST;
      thr_db_r     <= tbmis_pkg::THR_DB_RST;
      thr_max_r    <= tbmis_pkg::THR_MAX_RST;
      brk_min_r    <= tbmis_pkg::BRK_MIN_RST;
      brk_max_r    <= tbmis_pkg::BRK_MAX_RST;
      debounce_r   <= tbmis_pkg::DEBOUNCE_RST;
      long_press_r <= tbmis_pkg::LONG_PRESS_RST;
      send_int_r   <= tbmis_pkg::SEND_INT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tbmis_pkg::CFG_THR_MIN:    thr_min_r    <= cfg_data[SW-1:0];
        tbmis_pkg::CFG_THR_DB:     thr_db_r     <= cfg_data[SW-1:0];
        tbmis_pkg::CFG_THR_MAX:    thr_max_r    <= cfg_data[SW-1:0];
        tbmis_pkg::CFG_BRK_MIN:    brk_min_r    <= cfg_data[SW-1:0];
        tbmis_pkg::CFG_BRK_MAX:    brk_max_r    <= cfg_data[SW-1:0];
        tbmis_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_data;
        tbmis_pkg::CFG_LONG_PRESS: long_press_r <= cfg_data;
        tbmis_pkg::CFG_SEND_INT:   send_int_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r  <= in_now_ms;
      thr_r  <= in_throttle_sample;
      brk_r  <= in_brake_sample;
      btn_r  <= in_button_pressed;
      link_r <= in_link_connected;
      err_r  <= in_error_active;
    end
  end

  // operand prep: start level, clamp, range
  logic [CW-1:0] smp_ext, start_ext, top_ext, clamp_ext;
  logic          below, empty;
  logic [SW-1:0] diff_nxt, den_nxt;

  always_comb begin
    smp_ext = cmd.sel_brk ? CW'(brk_r) : CW'(thr_r);
    start_ext = cmd.sel_brk ? CW'(brk_min_r) : (CW'(thr_min_r) + CW'(thr_db_r));
    top_ext   = cmd.sel_brk ? CW'(brk_max_r) : CW'(thr_max_r);
    below     = smp_ext < start_ext;
    empty     = top_ext <= start_ext;
    clamp_ext = (smp_ext > top_ext) ? top_ext : smp_ext;
    diff_nxt  = SW'(clamp_ext - start_ext);
    den_nxt   = SW'(top_ext - start_ext);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      diff_r <= diff_nxt;
      den_r  <= den_nxt;
      zero_r <= below || empty;
    end
    if (cmd.store_thr) begin
      thr_quo_r  <= div_quo[PW-1:0];
      thr_zero_r <= zero_r;
    end
  end

  tbmis_div #(
    .NUM_W (tbmis_pkg::NUM_W),
    .DEN_W (tbmis_pkg::DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (tbmis_pkg::mul_scale(diff_r)),
    .den   (den_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    sts          = '0;
    sts.div_done = div_done && !div_busy;
  end

  // finish: brake override, button, leds, send timer
  logic [PW-1:0]        brk_pct, thr_pct;
  logic [TIME_BITS-1:0] held, elapsed;
  logic                 press, release_ok, send_due;
  logic [MW-1:0]        mode_nxt;
  logic [tbmis_pkg::LED_W-1:0] led_nxt;

  always_comb begin
    brk_pct    = zero_r ? '0 : div_quo[PW-1:0];
    thr_pct    = (thr_zero_r || (brk_pct > tbmis_pkg::BRAKE_OVERRIDE)) ? '0 : thr_quo_r;
    press      = btn_r && !btn_before_r;
    held       = now_r - press_start_r;
    release_ok = !btn_r && btn_before_r &&
                 (held >= TIME_BITS'(debounce_r)) && (held < TIME_BITS'(long_press_r));
    mode_nxt   = mode_r;
    if (release_ok) begin
      mode_nxt = (mode_r == tbmis_pkg::MODE_SPORT) ? tbmis_pkg::MODE_ECO : mode_r + 1'b1;
    end
    elapsed  = now_r - last_send_r;
    send_due = elapsed >= TIME_BITS'(send_int_r);
    led_nxt  = {err_r,
                mode_nxt == tbmis_pkg::MODE_SPORT,
                mode_nxt == tbmis_pkg::MODE_DRIVE,
                mode_nxt == tbmis_pkg::MODE_ECO,
                link_r,
                1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_before_r  <= 1'b0;
      press_start_r <= '0;
      last_send_r   <= '0;
      mode_r        <= tbmis_pkg::MODE_DRIVE;
    end else if (cmd.finish) begin
      btn_before_r <= btn_r;
      mode_r       <= mode_nxt;
      if (press) begin
        press_start_r <= now_r;
      end
      if (send_due) begin
        last_send_r <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_thr_r  <= thr_pct;
      o_brk_r  <= brk_pct;
      o_chg_r  <= release_ok;
      o_send_r <= send_due;
      o_led_r  <= led_nxt;
    end
  end

  assign out_throttle_percent = o_thr_r;
  assign out_brake_percent    = o_brk_r;
  assign out_mode_now         = o_led_r[4] ? tbmis_pkg::MODE_SPORT :
                                o_led_r[3] ? tbmis_pkg::MODE_DRIVE : tbmis_pkg::MODE_ECO;
  assign out_mode_changed     = o_chg_r;
  assign out_send_control     = o_send_r;
  assign out_led_pattern      = o_led_r;

  `TBMIS_ASSERT_NOW(a_mode_range, 1'b1, mode_r != 2'd3, "riding mode out of range")

endmodule

FILE: hw/rtl/tbmis_ctrl.sv
`include "throttle_brake_mode_input_scanner_defines.svh"

module tbmis_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output tbmis_pkg::cmd_t cmd,
  input  tbmis_pkg::sts_t sts
);

  tbmis_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbmis_pkg::S_IDLE:   if (in_valid) state_nxt = tbmis_pkg::S_PREP_T;
      tbmis_pkg::S_PREP_T: state_nxt = tbmis_pkg::S_DIV_T;
      tbmis_pkg::S_DIV_T:  state_nxt = tbmis_pkg::S_WAIT_T;
      tbmis_pkg::S_WAIT_T: if (sts.div_done) state_nxt = tbmis_pkg::S_PREP_B;
      tbmis_pkg::S_PREP_B: state_nxt = tbmis_pkg::S_DIV_B;
      tbmis_pkg::S_DIV_B:  state_nxt = tbmis_pkg::S_WAIT_B;
      tbmis_pkg::S_WAIT_B: if (sts.div_done) state_nxt = tbmis_pkg::S_FINISH;
      tbmis_pkg::S_FINISH: if (out_free) state_nxt = tbmis_pkg::S_IDLE;
      default:             state_nxt = tbmis_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      tbmis_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      tbmis_pkg::S_PREP_T: cmd.prep = 1'b1;
      tbmis_pkg::S_DIV_T:  cmd.div_start = 1'b1;
      tbmis_pkg::S_WAIT_T: cmd.store_thr = sts.div_done;
      tbmis_pkg::S_PREP_B: begin
        cmd.prep    = 1'b1;
        cmd.sel_brk = 1'b1;
      end
      tbmis_pkg::S_DIV_B:  cmd.div_start = 1'b1;
      tbmis_pkg::S_WAIT_B: ;
      tbmis_pkg::S_FINISH: cmd.finish = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tbmis_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TBMIS_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == tbmis_pkg::S_PREP_T,
    "accepted request did not start")
  `TBMIS_ASSERT_NOW(a_valid_from_finish, $rose(out_valid_r),
    $past(state_r == tbmis_pkg::S_FINISH), "result raised outside finish")
  `TBMIS_ASSERT_NEXT(a_finish_leaves, cmd.finish, state_r == tbmis_pkg::S_IDLE && out_valid_r,
    "finish did not load the result")

endmodule

FILE: hw/rtl/throttle_brake_mode_input_scanner.sv
// channel  | direction | handshake                | payload
// in       | input     | in_valid / in_ready      | one scan: time, samples, button, flags
// out      | output    | out_valid / out_ready    | percents, mode, change, send, leds
// cfg      | input     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// each request runs the shared bit-serial divider once for throttle and once for
// brake.
// reset is synchronous on rst_n; registers return to their defaults, mode to drive.
// a finished result sits in the output register; the next request is taken
// while it waits; only the final step stalls, when that result still waits
// and out_ready is low. cfg_ready is always high.
module throttle_brake_mode_input_scanner #(
  parameter int SAMPLE_BITS = tbmis_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = tbmis_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [TIME_BITS-1:0]              in_now_ms,
  input  logic [SAMPLE_BITS-1:0]            in_throttle_sample,
  input  logic [SAMPLE_BITS-1:0]            in_brake_sample,
  input  logic                              in_button_pressed,
  input  logic                              in_link_connected,
  input  logic                              in_error_active,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tbmis_pkg::PCT_W-1:0]       out_throttle_percent,
  output logic [tbmis_pkg::PCT_W-1:0]       out_brake_percent,
  output logic [tbmis_pkg::MODE_W-1:0]      out_mode_now,
  output logic                              out_mode_changed,
  output logic                              out_send_control,
  output logic [tbmis_pkg::LED_W-1:0]       out_led_pattern,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tbmis_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbmis_pkg::CFG_TW-1:0]      cfg_data
);

  tbmis_pkg::cmd_t cmd;
  tbmis_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  tbmis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tbmis_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_now_ms            (in_now_ms),
    .in_throttle_sample   (in_throttle_sample),
    .in_brake_sample      (in_brake_sample),
    .in_button_pressed    (in_button_pressed),
    .in_link_connected    (in_link_connected),
    .in_error_active      (in_error_active),
    .out_throttle_percent (out_throttle_percent),
    .out_brake_percent    (out_brake_percent),
    .out_mode_now         (out_mode_now),
    .out_mode_changed     (out_mode_changed),
    .out_send_control     (out_send_control),
    .out_led_pattern      (out_led_pattern)
  );

endmodule

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = tbmis_pkg::SAMPLE_BITS_DEF;
  localparam int TW = tbmis_pkg::TIME_BITS_DEF;

  localparam int LED_PWR  = 0;
  localparam int LED_LINK = 1;
  localparam int LED_ECO  = 2;
  localparam int LED_ERR  = 5;

  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 65;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum int {PLAN_TYPICAL, PLAN_WIDE, PLAN_EMPTY, PLAN_ONES, PLAN_RANDOM} cfg_plan_t;

  typedef struct {
    logic [TW-1:0] now;
    logic [SW-1:0] thr;
    logic [SW-1:0] brk;
    logic          btn;
    logic          link;
    logic          err;
  } scan_t;

  typedef struct {
    logic [tbmis_pkg::PCT_W-1:0]  thr_pct;
    logic [tbmis_pkg::PCT_W-1:0]  brk_pct;
    logic [tbmis_pkg::MODE_W-1:0] mode;
    logic                         changed;
    logic                         send;
    logic [tbmis_pkg::LED_W-1:0]  leds;
  } result_t;

  class scan_scoreboard;
    logic [tbmis_pkg::CFG_SW-1:0] thr_min, thr_db, thr_max, brk_min, brk_max;
    logic [tbmis_pkg::CFG_TW-1:0] debounce, long_press, send_int;
    logic                         btn_prev;
    logic [TW-1:0]                press_t0;
    logic [TW-1:0]                last_send;
    logic [tbmis_pkg::MODE_W-1:0] mode;
    result_t                      expected_q[$];
    int                           mismatches;

    function new();
      thr_min    = tbmis_pkg::THR_MIN_RST;
      thr_db     = tbmis_pkg::THR_DB_RST;
      thr_max    = tbmis_pkg::THR_MAX_RST;
      brk_min    = tbmis_pkg::BRK_MIN_RST;
      brk_max    = tbmis_pkg::BRK_MAX_RST;
      debounce   = tbmis_pkg::DEBOUNCE_RST;
      long_press = tbmis_pkg::LONG_PRESS_RST;
      send_int   = tbmis_pkg::SEND_INT_RST;
      btn_prev   = 1'b0;
      press_t0   = '0;
      last_send  = '0;
      mode       = tbmis_pkg::MODE_DRIVE;
      mismatches = 0;
    endfunction

    function void set_reg(logic [tbmis_pkg::CFG_IDX_W-1:0] idx,
                          logic [tbmis_pkg::CFG_TW-1:0] d);
      case (idx)
        tbmis_pkg::CFG_THR_MIN:    thr_min    = d[tbmis_pkg::CFG_SW-1:0];
        tbmis_pkg::CFG_THR_DB:     thr_db     = d[tbmis_pkg::CFG_SW-1:0];
        tbmis_pkg::CFG_THR_MAX:    thr_max    = d[tbmis_pkg::CFG_SW-1:0];
        tbmis_pkg::CFG_BRK_MIN:    brk_min    = d[tbmis_pkg::CFG_SW-1:0];
        tbmis_pkg::CFG_BRK_MAX:    brk_max    = d[tbmis_pkg::CFG_SW-1:0];
        tbmis_pkg::CFG_DEBOUNCE:   debounce   = d;
        tbmis_pkg::CFG_LONG_PRESS: long_press = d;
        tbmis_pkg::CFG_SEND_INT:   send_int   = d;
        default: ;
      endcase
    endfunction

    function int unsigned pct(int unsigned sample, int unsigned start, int unsigned top);
      if (sample < start || top <= start) return 0;
      if (sample > top) sample = top;
      return ((sample - start) * tbmis_pkg::PCT_SCALE) / (top - start);
    endfunction

    function void note_scan(scan_t s);
      result_t       r;
      logic [TW-1:0] held;
      logic [TW-1:0] elapsed;
      r.thr_pct = tbmis_pkg::PCT_W'(pct(32'(s.thr), 32'(thr_min) + 32'(thr_db),
                                        32'(thr_max)));
      r.brk_pct = tbmis_pkg::PCT_W'(pct(32'(s.brk), 32'(brk_min), 32'(brk_max)));
      if (r.brk_pct > tbmis_pkg::BRAKE_OVERRIDE) r.thr_pct = '0;
      r.changed = 1'b0;
      if (s.btn && !btn_prev) press_t0 = s.now;
      if (!s.btn && btn_prev) begin
        held = s.now - press_t0;
        if (held >= TW'(debounce) && held < TW'(long_press)) begin
          mode = (mode == tbmis_pkg::MODE_SPORT) ? tbmis_pkg::MODE_ECO : mode + 1'b1;
          r.changed = 1'b1;
        end
      end
      btn_prev = s.btn;
      r.mode = mode;
      r.leds = '0;
      r.leds[LED_PWR] = 1'b1;
      r.leds[LED_LINK] = s.link;
      r.leds[LED_ERR] = s.err;
      r.leds[LED_ECO + int'(mode)] = 1'b1;
      elapsed = s.now - last_send;
      r.send = 1'b0;
      if (elapsed >= TW'(send_int)) begin
        last_send = s.now;
        r.send = 1'b1;
      end
      expected_q.push_back(r);
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got)
        note_failure($sformatf("mismatch %s: expected %0d, got %0d", field, want, got));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        note_failure("result with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      compare_field("throttle_percent", want.thr_pct, got.thr_pct);
      compare_field("brake_percent", want.brk_pct, got.brk_pct);
      compare_field("mode_now", want.mode, got.mode);
      compare_field("mode_changed", want.changed, got.changed);
      compare_field("send_control", want.send, got.send);
      compare_field("led_pattern", want.leds, got.leds);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [TW-1:0]                   in_now_ms = '0;
  logic [SW-1:0]                   in_throttle_sample = '0;
  logic [SW-1:0]                   in_brake_sample = '0;
  logic                            in_button_pressed = 1'b0;
  logic                            in_link_connected = 1'b0;
  logic                            in_error_active = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [tbmis_pkg::PCT_W-1:0]     out_throttle_percent;
  logic [tbmis_pkg::PCT_W-1:0]     out_brake_percent;
  logic [tbmis_pkg::MODE_W-1:0]    out_mode_now;
  logic                            out_mode_changed;
  logic                            out_send_control;
  logic [tbmis_pkg::LED_W-1:0]     out_led_pattern;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [tbmis_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tbmis_pkg::CFG_TW-1:0]    cfg_data = '0;

  scan_scoreboard sb = new();
  idle_mode_t     idle_mode = IDLE_NONE;
  int             hold_req = 0;
  logic [TW-1:0]  tick_ms = '0;
  logic [tbmis_pkg::CFG_TW-1:0] reg_plan [8];
  cfg_plan_t plan_seq [NUM_PHASES] = '{PLAN_TYPICAL, PLAN_WIDE, PLAN_EMPTY, PLAN_ONES,
                                      PLAN_TYPICAL, PLAN_TYPICAL, PLAN_RANDOM, PLAN_WIDE,
                                      PLAN_TYPICAL, PLAN_RANDOM};

  throttle_brake_mode_input_scanner DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_now_ms(in_now_ms),
    .in_throttle_sample(in_throttle_sample),
    .in_brake_sample(in_brake_sample),
    .in_button_pressed(in_button_pressed),
    .in_link_connected(in_link_connected),
    .in_error_active(in_error_active),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_throttle_percent(out_throttle_percent),
    .out_brake_percent(out_brake_percent),
    .out_mode_now(out_mode_now),
    .out_mode_changed(out_mode_changed),
    .out_send_control(out_send_control),
    .out_led_pattern(out_led_pattern),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("tb: done, errors");
    $finish;
  end

  function automatic int send_idle_pct();
    return (idle_mode == IDLE_SEND) ? 73 : (idle_mode == IDLE_BOTH) ? 34 : 0;
  endfunction

  function automatic int recv_stall_pct();
    return (idle_mode == IDLE_RECV) ? 73 : (idle_mode == IDLE_BOTH) ? 34 : 0;
  endfunction

  // receiver: checks results, stalls at random, long hold-off on request
  initial begin
    result_t got;
    int      hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.thr_pct = out_throttle_percent;
        got.brk_pct = out_brake_percent;
        got.mode    = out_mode_now;
        got.changed = out_mode_changed;
        got.send    = out_send_control;
        got.leds    = out_led_pattern;
        sb.check_result(got);
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct());
      end
    end
  end

  function automatic scan_t scan_at(logic [TW-1:0] t, logic [SW-1:0] thr, logic [SW-1:0] brk,
                                    logic btn, logic link, logic err);
    scan_t s;
    s.now = t;
    s.thr = thr;
    s.brk = brk;
    s.btn = btn;
    s.link = link;
    s.err = err;
    return s;
  endfunction

  // samples biased toward the start level, the clamp point and the rails
  function automatic logic [SW-1:0] pick_level(int unsigned start, int unsigned top);
    int unsigned v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 4095;
      2: v = start - 1 + $urandom_range(0, 2);
      3: v = top - 1 + $urandom_range(0, 2);
      4: v = $urandom_range(start, top);
      default: v = $urandom_range(0, 4095);
    endcase
    return v[SW-1:0];
  endfunction

  function automatic scan_t next_scan(logic btn);
    return scan_at(tick_ms,
                   pick_level(32'(sb.thr_min) + 32'(sb.thr_db), 32'(sb.thr_max)),
                   pick_level(32'(sb.brk_min), 32'(sb.brk_max)),
                   btn, 1'($urandom), 1'($urandom));
  endfunction

  // press lengths around the debounce and long-press edges
  function automatic int unsigned pick_held();
    int unsigned deb;
    int unsigned lp;
    deb = sb.debounce;
    lp = sb.long_press;
    case ($urandom_range(0, 7))
      0: return deb - 1;
      1: return deb;
      2: return deb + 1;
      3: return lp - 1;
      4: return lp;
      5: return $urandom_range(deb, lp);
      6: return $urandom_range(0, 200);
      default: return $urandom();
    endcase
  endfunction

  task automatic advance_time();
    if ($urandom_range(9) == 0) tick_ms = tick_ms + $urandom_range(0, 70000);
    else tick_ms = tick_ms + $urandom_range(1, 40);
  endtask

  task automatic send_scan(scan_t s);
    while ($urandom_range(99) < send_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_now_ms          <= s.now;
    in_throttle_sample <= s.thr;
    in_brake_sample    <= s.brk;
    in_button_pressed  <= s.btn;
    in_link_connected  <= s.link;
    in_error_active    <= s.err;
    do @(posedge clk); while (!in_ready);
    sb.note_scan(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_config();
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= tbmis_pkg::CFG_IDX_W'(i);
      cfg_data  <= reg_plan[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(tbmis_pkg::CFG_IDX_W'(i), reg_plan[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_config(cfg_plan_t plan);
    int unsigned deb;
    case (plan)
      PLAN_TYPICAL: begin
        deb = $urandom_range(0, 100);
        reg_plan[tbmis_pkg::CFG_THR_MIN]    = {4'($urandom), 12'($urandom_range(0, 1000))};
        reg_plan[tbmis_pkg::CFG_THR_DB]     = {4'($urandom), 12'($urandom_range(0, 200))};
        reg_plan[tbmis_pkg::CFG_THR_MAX]    = {4'($urandom), 12'($urandom_range(2000, 4095))};
        reg_plan[tbmis_pkg::CFG_BRK_MIN]    = {4'($urandom), 12'($urandom_range(0, 1000))};
        reg_plan[tbmis_pkg::CFG_BRK_MAX]    = {4'($urandom), 12'($urandom_range(2000, 4095))};
        reg_plan[tbmis_pkg::CFG_DEBOUNCE]   = 16'(deb);
        reg_plan[tbmis_pkg::CFG_LONG_PRESS] = 16'($urandom_range(deb + 1, 3000));
        reg_plan[tbmis_pkg::CFG_SEND_INT]   = 16'($urandom_range(1, 200));
      end
      PLAN_WIDE: begin
        reg_plan[tbmis_pkg::CFG_THR_MIN]    = 16'd0;
        reg_plan[tbmis_pkg::CFG_THR_DB]     = 16'd0;
        reg_plan[tbmis_pkg::CFG_THR_MAX]    = 16'd4095;
        reg_plan[tbmis_pkg::CFG_BRK_MIN]    = 16'd0;
        reg_plan[tbmis_pkg::CFG_BRK_MAX]    = 16'd4095;
        reg_plan[tbmis_pkg::CFG_DEBOUNCE]   = 16'd0;
        reg_plan[tbmis_pkg::CFG_LONG_PRESS] = 16'hFFFF;
        reg_plan[tbmis_pkg::CFG_SEND_INT]   = 16'd1;
      end
      PLAN_EMPTY: begin
        // throttle range empty or inverted, brake range the same, no press can count
        reg_plan[tbmis_pkg::CFG_THR_MIN]    = 16'd3000;
        reg_plan[tbmis_pkg::CFG_THR_DB]     = 16'd500;
        reg_plan[tbmis_pkg::CFG_THR_MAX]    = $urandom_range(1) ? 16'd3500 : 16'd3200;
        reg_plan[tbmis_pkg::CFG_BRK_MIN]    = 16'd2000;
        reg_plan[tbmis_pkg::CFG_BRK_MAX]    = $urandom_range(1) ? 16'd2000 : 16'd1500;
        reg_plan[tbmis_pkg::CFG_DEBOUNCE]   = 16'd500;
        reg_plan[tbmis_pkg::CFG_LONG_PRESS] = 16'd400;
        reg_plan[tbmis_pkg::CFG_SEND_INT]   = 16'd0;
      end
      PLAN_ONES: begin
        for (int i = 0; i < 8; i++) reg_plan[i] = 16'hFFFF;
      end
      default: begin
        for (int i = 0; i < 8; i++) reg_plan[i] = 16'($urandom);
      end
    endcase
  endtask

  // mostly complete press/release sequences, some noise scans
  task automatic run_random(int n);
    int            sent;
    int            k;
    int unsigned   held;
    logic [TW-1:0] t0;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 80) begin
        k = $urandom_range(0, 2);
        repeat (k) begin
          advance_time();
          send_scan(next_scan(1'b0));
          sent++;
        end
        advance_time();
        t0 = tick_ms;
        send_scan(next_scan(1'b1));
        sent++;
        held = pick_held();
        k = $urandom_range(0, 2);
        for (int i = 1; i <= k; i++) begin
          tick_ms = t0 + (held / (k + 1)) * i;
          send_scan(next_scan(1'b1));
          sent++;
        end
        tick_ms = t0 + held;
        send_scan(next_scan(1'b0));
        sent++;
      end else begin
        if ($urandom_range(3) == 0) tick_ms = $urandom();
        else advance_time();
        send_scan(next_scan(1'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: rails, start and clamp levels, brake override edge
    send_scan(scan_at(32'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0));
    send_scan(scan_at(32'd10, 12'd4095, 12'd4095, 1'b0, 1'b1, 1'b1));
    send_scan(scan_at(32'd60, 12'd4095, 12'd0, 1'b0, 1'b0, 1'b1));
    send_scan(scan_at(32'd61, 12'd450, 12'd400, 1'b0, 1'b1, 1'b0));
    send_scan(scan_at(32'd62, 12'd449, 12'd3400, 1'b0, 1'b0, 1'b0));
    send_scan(scan_at(32'd63, 12'd4095, 12'd579, 1'b0, 1'b1, 1'b0));
    send_scan(scan_at(32'd64, 12'd4095, 12'd580, 1'b0, 1'b0, 1'b1));
    // press lengths: debounce exactly, one short, long exactly, one below long
    send_scan(scan_at(32'd100, 12'd3000, 12'd0, 1'b1, 1'b1, 1'b0));
    send_scan(scan_at(32'd150, 12'd3000, 12'd0, 1'b0, 1'b1, 1'b0));
    send_scan(scan_at(32'd200, 12'd1000, 12'd0, 1'b1, 1'b0, 1'b0));
    send_scan(scan_at(32'd249, 12'd1000, 12'd0, 1'b0, 1'b0, 1'b0));
    send_scan(scan_at(32'd300, 12'd1000, 12'd0, 1'b1, 1'b0, 1'b0));
    send_scan(scan_at(32'd2300, 12'd1000, 12'd0, 1'b0, 1'b0, 1'b0));
    send_scan(scan_at(32'd2400, 12'd1000, 12'd0, 1'b1, 1'b1, 1'b1));
    send_scan(scan_at(32'd4399, 12'd1000, 12'd0, 1'b0, 1'b1, 1'b1));
    send_scan(scan_at(32'd4500, 12'd2000, 12'd500, 1'b1, 1'b0, 1'b0));
    send_scan(scan_at(32'd4600, 12'd2000, 12'd500, 1'b0, 1'b0, 1'b0));
    // press across the tick wrap, then a very long press
    send_scan(scan_at(32'hFFFF_FFE0, 12'd3400, 12'd3400, 1'b1, 1'b1, 1'b0));
    send_scan(scan_at(32'h0000_0040, 12'd3401, 12'd399, 1'b0, 1'b1, 1'b0));
    send_scan(scan_at(32'h0000_0041, 12'd451, 12'd401, 1'b0, 1'b1, 1'b0));
    send_scan(scan_at(32'hFFFF_FFFF, 12'd4095, 12'd4095, 1'b1, 1'b1, 1'b1));
    send_scan(scan_at(32'h7FFF_FFFF, 12'd4095, 12'd0, 1'b0, 1'b0, 1'b1));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_mode = idle_mode_t'(p % 4);
      plan_config(plan_seq[p]);
      write_config();
      if (p == 4) begin
        // receiver holds off while requests keep coming
        run_random(20);
        hold_req = HOLD_CYCLES;
        run_random(PHASE_ITEMS - 20);
      end else begin
        run_random(PHASE_ITEMS);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tbmis_pkg.sv
hw/rtl/tbmis_div.sv
hw/rtl/tbmis_dp.sv
hw/rtl/tbmis_ctrl.sv
hw/rtl/throttle_brake_mode_input_scanner.sv
bench/tb.sv
